### design/brau_pkg.sv
package brau_pkg;

  localparam int POOL_W     = 10;
  localparam int BYTE_IDX_W = 9;
  localparam int LEN_W      = 13;
  localparam int START_W    = 12;
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = 1;

  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_TEST  = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;
  localparam logic [1:0] CMD_SCAN  = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_RANGE    = 2'd2;

  localparam logic [2:0] OP_CLEAR    = 3'd0;
  localparam logic [2:0] OP_TEST     = 3'd1;
  localparam logic [2:0] OP_WRITE    = 3'd2;
  localparam logic [2:0] OP_SCAN     = 3'd3;
  localparam logic [2:0] OP_RANGE    = 3'd4;
  localparam logic [2:0] OP_NOTFOUND = 3'd5;

  typedef struct packed {
    logic [1:0]  command;
    logic [11:0] bit_index;
    logic        bit_value;
    logic [12:0] run_length;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        bit_read;
    logic [11:0] run_start;
  } out_item_t;

  typedef struct packed {
    logic [2:0]            op;
    logic [BYTE_IDX_W-1:0] byte_addr;
    logic [2:0]            bit_sel;
    logic                  bit_value;
    logic [LEN_W-1:0]      run_length;
  } op_t;

endpackage

### design/bitmap_run_allocator_unit.sv
// Bitmap run allocator: first-fit search for contiguous free units.
// Input channel (in_valid/in_ready/in_item) carries one command per
// transaction: clear all, test a bit, write a bit, or scan for a free run.
// Output channel (out_valid/out_ready/out_item) returns exactly one result
// transaction per command, in command order.
// cfg_we/cfg_wdata set the pool size in bytes; write it only while idle.
// Path from acceptance to out_valid, with the output free:
//   test, write: queue, S_IDLE, S_TEST or S_WRITE, S_DONE, output register.
//   range error, rejected scan: queue, S_IDLE, S_DONE, output register.
//   scan: as test, through S_SCAN; the scan engine fetches one byte per cycle
//         over the single memory read port until the hit or the pool's end.
//   clear: as test, through S_CLEAR; one byte of the store zeroed per cycle.
// Commands run one at a time in the back end; a two-entry queue lets the
// front keep accepting while a result waits for out_ready.
// Reset (rst_n low, synchronous) starts a clearing pass over the whole store
// of MAX_BYTES bytes; in_ready stays low until it ends. Configuration writes are
// taken during it, and the pool size resets to 512 bytes.
// When the receiver stalls, the result holds in the output register, the
// back end holds its next result, and in_ready drops once the queue fills.
module bitmap_run_allocator_unit #(
  parameter int MAX_BYTES = 512
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  brau_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output brau_pkg::out_item_t out_item,
  input  logic                cfg_we,
  input  logic [9:0]          cfg_wdata
);

  // largest pool the 10-bit register can name, capped at the store size
  localparam int POOL_CAP = (MAX_BYTES > 1023) ? 1023 : MAX_BYTES;

  logic [brau_pkg::POOL_W-1:0] bytes_r, bytes_nxt;
  logic [brau_pkg::POOL_W-1:0] pool;

  logic          push;
  brau_pkg::op_t push_op;
  logic          q_full;
  logic          q_valid;
  logic          q_pop;
  brau_pkg::op_t q_op;
  logic          init_busy;

  assign bytes_nxt = cfg_we ? cfg_wdata : bytes_r;
  assign pool      = (bytes_r > brau_pkg::POOL_W'(POOL_CAP)) ?
                     brau_pkg::POOL_W'(POOL_CAP) : bytes_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_r <= 10'd512;
    end else begin
      bytes_r <= bytes_nxt;
    end
  end

  // classify and enqueue
  brau_front u_front (
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .pool      (pool),
    .init_busy (init_busy),
    .q_full    (q_full),
    .push      (push),
    .push_op   (push_op)
  );

  brau_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_op (push_op),
    .pop     (q_pop),
    .full    (q_full),
    .valid   (q_valid),
    .head_op (q_op)
  );

  // execute against the bitmap store and drive results
  brau_back #(
    .MAX_BYTES (MAX_BYTES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pool      (pool),
    .q_valid   (q_valid),
    .q_op      (q_op),
    .q_pop     (q_pop),
    .init_busy (init_busy),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

### design/brau_front.sv
module brau_front (
  input  logic                        in_valid,
  output logic                        in_ready,
  input  brau_pkg::in_item_t          in_item,
  input  logic [brau_pkg::POOL_W-1:0] pool,
  input  logic                        init_busy,
  input  logic                        q_full,
  output logic                        push,
  output brau_pkg::op_t               push_op
);

  logic [brau_pkg::BYTE_IDX_W-1:0] byte_addr;
  logic                            out_of_pool;
  logic                            bad_len;

  assign byte_addr   = in_item.bit_index[11:3];
  assign out_of_pool = {1'b0, byte_addr} >= pool;
  // a run must be nonzero and fit inside the pool's bits
  assign bad_len     = (in_item.run_length == '0) ||
                       (in_item.run_length > {pool, 3'b000});

  assign in_ready = !q_full && !init_busy;
  assign push     = in_valid && in_ready;

  always_comb begin
    push_op.byte_addr  = byte_addr;
    push_op.bit_sel    = in_item.bit_index[2:0];
    push_op.bit_value  = in_item.bit_value;
    push_op.run_length = in_item.run_length;
    case (in_item.command)
      brau_pkg::CMD_CLEAR: push_op.op = brau_pkg::OP_CLEAR;
      brau_pkg::CMD_TEST:  push_op.op = out_of_pool ? brau_pkg::OP_RANGE : brau_pkg::OP_TEST;
      brau_pkg::CMD_WRITE: push_op.op = out_of_pool ? brau_pkg::OP_RANGE : brau_pkg::OP_WRITE;
      brau_pkg::CMD_SCAN:  push_op.op = bad_len ? brau_pkg::OP_NOTFOUND : brau_pkg::OP_SCAN;
      default:             push_op.op = brau_pkg::OP_CLEAR;
    endcase
  end

endmodule

### design/brau_queue.sv
module brau_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  brau_pkg::op_t push_op,
  input  logic          pop,
  output logic          full,
  output logic          valid,
  output brau_pkg::op_t head_op
);

  localparam int CNT_W = brau_pkg::QPTR_W + 1;

  brau_pkg::op_t               entry_r [brau_pkg::QDEPTH];
  logic [brau_pkg::QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [brau_pkg::QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]            count_r, count_nxt;

  assign full    = count_r == CNT_W'(brau_pkg::QDEPTH);
  assign valid   = count_r != '0;
  assign head_op = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + CNT_W'(push) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_op;
    end
  end

endmodule

### design/brau_back.sv
module brau_back #(
  parameter int MAX_BYTES = 512
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [brau_pkg::POOL_W-1:0] pool,
  input  logic                        q_valid,
  input  brau_pkg::op_t               q_op,
  output logic                        q_pop,
  output logic                        init_busy,
  output logic                        out_valid,
  input  logic                        out_ready,
  output brau_pkg::out_item_t         out_item
);

  localparam int ADDR_W = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAX_BYTES - 1);

  localparam logic [2:0] S_INIT  = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_CLEAR = 3'd2;
  localparam logic [2:0] S_TEST  = 3'd3;
  localparam logic [2:0] S_WRITE = 3'd4;
  localparam logic [2:0] S_SCAN  = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [7:0] mem [MAX_BYTES];

  logic [2:0]                    state_r, state_nxt;
  logic [ADDR_W-1:0]             sweep_r, sweep_nxt;
  brau_pkg::op_t                 cur_r, cur_nxt;
  logic [brau_pkg::POOL_W-1:0]   issue_r, issue_nxt;
  logic                          dvld_r, dvld_nxt;
  logic [brau_pkg::POOL_W-1:0]   didx_r, didx_nxt;
  logic [brau_pkg::LEN_W-1:0]    run_r, run_nxt;
  logic [brau_pkg::START_W-1:0]  cand_r, cand_nxt;
  brau_pkg::out_item_t           res_r, res_nxt;
  logic                          out_valid_r, out_valid_nxt;
  brau_pkg::out_item_t           out_item_r;
  logic [7:0]                    rd_data_r;

  logic                          we;
  logic [ADDR_W-1:0]             wa;
  logic [7:0]                    wd;
  logic [ADDR_W-1:0]             rd_addr;
  logic                          load;
  logic [7:0]                    bit_mask;

  logic [brau_pkg::LEN_W-1:0]    run_v;
  logic [brau_pkg::START_W-1:0]  cand_v;
  logic                          hit;
  logic [brau_pkg::START_W-1:0]  hit_start;

  assign init_busy = state_r == S_INIT;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign bit_mask  = 8'd1 << cur_r.bit_sel;

  // walk the eight bits of the fetched byte, lowest first
  always_comb begin
    run_v     = run_r;
    cand_v    = cand_r;
    hit       = 1'b0;
    hit_start = '0;
    for (int b = 0; b < 8; b++) begin
      if (!hit) begin
        if (rd_data_r[b]) begin
          run_v  = '0;
          cand_v = brau_pkg::START_W'({didx_r, 3'(b)} + 13'd1);
        end else begin
          run_v = run_v + 1'b1;
        end
        if (run_v == cur_r.run_length) begin
          hit       = 1'b1;
          hit_start = cand_v;
        end
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    sweep_nxt = sweep_r;
    cur_nxt   = cur_r;
    issue_nxt = issue_r;
    dvld_nxt  = dvld_r;
    didx_nxt  = didx_r;
    run_nxt   = run_r;
    cand_nxt  = cand_r;
    res_nxt   = res_r;
    q_pop     = 1'b0;
    we        = 1'b0;
    wa        = ADDR_W'(cur_r.byte_addr);
    wd        = '0;
    rd_addr   = ADDR_W'(issue_r);
    load      = 1'b0;
    case (state_r)
      S_INIT, S_CLEAR: begin
        we        = 1'b1;
        wa        = sweep_r;
        sweep_nxt = sweep_r + 1'b1;
        if (sweep_r == LAST_ADDR) begin
          sweep_nxt = '0;
          if (state_r == S_INIT) begin
            state_nxt = S_IDLE;
          end else begin
            res_nxt   = '{status: brau_pkg::ST_OK, bit_read: 1'b0, run_start: '0};
            state_nxt = S_DONE;
          end
        end
      end
      S_IDLE: begin
        rd_addr = ADDR_W'(q_op.byte_addr);
        if (q_valid) begin
          q_pop   = 1'b1;
          cur_nxt = q_op;
          case (q_op.op)
            brau_pkg::OP_CLEAR: state_nxt = S_CLEAR;
            brau_pkg::OP_TEST:  state_nxt = S_TEST;
            brau_pkg::OP_WRITE: state_nxt = S_WRITE;
            brau_pkg::OP_SCAN: begin
              issue_nxt = '0;
              dvld_nxt  = 1'b0;
              run_nxt   = '0;
              cand_nxt  = '0;
              state_nxt = S_SCAN;
            end
            brau_pkg::OP_RANGE: begin
              res_nxt   = '{status: brau_pkg::ST_RANGE, bit_read: 1'b0, run_start: '0};
              state_nxt = S_DONE;
            end
            default: begin
              res_nxt   = '{status: brau_pkg::ST_NOTFOUND, bit_read: 1'b0, run_start: '0};
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_TEST: begin
        res_nxt   = '{status: brau_pkg::ST_OK, bit_read: rd_data_r[cur_r.bit_sel],
                      run_start: '0};
        state_nxt = S_DONE;
      end
      S_WRITE: begin
        we        = 1'b1;
        wd        = cur_r.bit_value ? (rd_data_r | bit_mask) : (rd_data_r & ~bit_mask);
        res_nxt   = '{status: brau_pkg::ST_OK, bit_read: 1'b0, run_start: '0};
        state_nxt = S_DONE;
      end
      S_SCAN: begin
        // fetch one byte a cycle, evaluate it the cycle after
        if (issue_r != pool) begin
          issue_nxt = issue_r + 1'b1;
        end
        dvld_nxt = issue_r != pool;
        didx_nxt = issue_r;
        if (dvld_r) begin
          run_nxt  = run_v;
          cand_nxt = cand_v;
          if (hit) begin
            res_nxt   = '{status: brau_pkg::ST_OK, bit_read: 1'b0, run_start: hit_start};
            state_nxt = S_DONE;
          end else if (didx_r == pool - 1'b1) begin
            res_nxt   = '{status: brau_pkg::ST_NOTFOUND, bit_read: 1'b0, run_start: '0};
            state_nxt = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          load      = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      sweep_r     <= '0;
      dvld_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sweep_r     <= sweep_nxt;
      dvld_r      <= dvld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r   <= cur_nxt;
    issue_r <= issue_nxt;
    didx_r  <= didx_nxt;
    run_r   <= run_nxt;
    cand_r  <= cand_nxt;
    res_r   <= res_nxt;
    if (load) begin
      out_item_r <= res_r;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data_r <= mem[rd_addr];
  end

endmodule
